@@ rtl/prq_pkg.sv @@
// ----------------------------------------------------------------------------
// prq_pkg: shared types and constants of the priority ready queue
// Task and level widths, request and outcome codes, level search result.
// ----------------------------------------------------------------------------
`default_nettype none

package prq_pkg;

  localparam int NUM_TASKS  = 64;
  localparam int TASK_W     = $clog2(NUM_TASKS);
  localparam int NUM_LEVELS = 32;
  localparam int LEVEL_W    = $clog2(NUM_LEVELS);

  typedef logic [TASK_W-1:0]     task_t;
  typedef logic [LEVEL_W-1:0]    level_t;
  typedef logic [NUM_LEVELS-1:0] bitmap_t;

  // request kinds
  localparam logic [1:0] FUNC_ADD_TAIL = 2'd0;
  localparam logic [1:0] FUNC_ADD_HEAD = 2'd1;
  localparam logic [1:0] FUNC_REMOVE   = 2'd2;

  // outcome codes
  localparam logic [1:0] OUT_DONE    = 2'd0;
  localparam logic [1:0] OUT_BLOCKED = 2'd1;
  localparam logic [1:0] OUT_IGNORED = 2'd2;

  // most urgent non-empty level
  typedef struct packed {
    logic   found;
    level_t level;
  } lvl_find_t;

endpackage

`default_nettype wire

@@ rtl/prq_lvl_enc.sv @@
// ----------------------------------------------------------------------------
// prq_lvl_enc: most urgent level finder
// Priority encoder over the level bitmap; bit NUM_LEVELS-1 is level 0.
// ----------------------------------------------------------------------------
`default_nettype none

module prq_lvl_enc (
  input  prq_pkg::bitmap_t   bitmap_i,
  output prq_pkg::lvl_find_t find_o
);
  import prq_pkg::*;

  always_comb begin
    find_o.found = |bitmap_i;
    find_o.level = '0;
    // higher bit index means more urgent level, so it wins last
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (bitmap_i[i]) begin
        find_o.level = LEVEL_W'(NUM_LEVELS - 1 - i);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/priority_bitmap_ready_queue.sv @@
// ----------------------------------------------------------------------------
// priority_bitmap_ready_queue: scheduler ready queue with level bitmap
// Task lists per priority level (add at tail or head) kept in small link memories.
// ----------------------------------------------------------------------------
// One request is worked at a time. An add accepts and reads the level ends,
// links, reads the new highest head and presents; a remove reads the task
// links and level, reads the level ends, unlinks, reads the new head and
// presents; an ignored request is accepted, reads the new head and presents.
// The steps follow from the registered reads of the link, level and
// head/tail memories, each with a single read and a single write port. The
// next request is taken while a result still waits in the output register.
// No clearing pass is needed after reset: only the queued flags and the
// level bitmap are cleared, and the memories are read only where written.
`default_nettype none

module priority_bitmap_ready_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: idle task number
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  // requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // task_index[5:0], task_prio[10:6], task_blocked[11]
  input  logic [1:0]  s_axis_tuser,  // func[1:0]
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // highest_task[5:0], highest_is_idle[6],
                                     // ready_levels[38:7], outcome[40:39]
);
  import prq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LINK,
    S_UNL_RD,
    S_UNL_WR,
    S_RPT,
    S_OUT
  } state_e;

  state_e             state_q;
  task_t              t_q;
  level_t             p_q;
  logic               at_head_q;
  logic [1:0]         outcome_q;
  task_t              idle_task_q;
  bitmap_t            bitmap_q, bitmap_d;
  logic [NUM_TASKS-1:0] queued_q, queued_d;

  logic               out_valid_q;
  task_t              out_task_q;
  logic               out_idle_q;
  bitmap_t            out_levels_q;
  logic [1:0]         out_outcome_q;

  // memories
  task_t  next_mem [NUM_TASKS];
  task_t  prev_mem [NUM_TASKS];
  level_t prio_mem [NUM_TASKS];
  task_t  head_mem [NUM_LEVELS];
  task_t  tail_mem [NUM_LEVELS];

  task_t  next_rd_q, prev_rd_q, head_rd_q, tail_rd_q;
  level_t prio_rd_q;

  logic   next_we, prev_we, head_we, tail_we, prio_we;
  task_t  next_wa, prev_wa, next_wd, prev_wd, head_wd, tail_wd;
  task_t  task_ra;
  level_t lvl_ra;

  // request fields
  task_t      idx_in;
  level_t     prio_in, prio_sat;
  logic       blocked_in;
  logic [1:0] func_in;
  logic       s_hs;
  logic [1:0] outcome_d;
  logic       go_link, go_unlink;

  lvl_find_t  find;
  bitmap_t    p_mask;
  logic       first, last;

  assign idx_in     = s_axis_tdata[5:0];
  assign prio_in    = s_axis_tdata[10:6];
  assign blocked_in = s_axis_tdata[11];
  assign func_in    = s_axis_tuser;
  assign prio_sat   = ({1'b0, prio_in} > (LEVEL_W+1)'(NUM_LEVELS - 1)) ?
                      LEVEL_W'(NUM_LEVELS - 1) : prio_in;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_hs          = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_outcome_q, out_levels_q, out_idle_q, out_task_q};

  prq_lvl_enc u_lvl_enc (
    .bitmap_i (bitmap_q),
    .find_o   (find)
  );

  assign p_mask = bitmap_t'(1) << (LEVEL_W'(NUM_LEVELS - 1) - p_q);
  assign first  = (head_rd_q == t_q);
  assign last   = (tail_rd_q == t_q);

  // classify the request at acceptance
  always_comb begin
    outcome_d = OUT_DONE;
    go_link   = 1'b0;
    go_unlink = 1'b0;
    case (func_in)
      FUNC_ADD_TAIL, FUNC_ADD_HEAD: begin
        if (blocked_in) begin
          outcome_d = OUT_BLOCKED;
        end else if (queued_q[idx_in]) begin
          outcome_d = OUT_IGNORED;
        end else begin
          go_link = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (!queued_q[idx_in]) begin
          outcome_d = OUT_IGNORED;
        end else begin
          go_unlink = 1'b1;
        end
      end
      default: begin
        outcome_d = OUT_DONE;
      end
    endcase
  end

  // read addresses
  assign task_ra = (state_q == S_IDLE) ? idx_in : t_q;

  always_comb begin
    case (state_q)
      S_IDLE:   lvl_ra = prio_sat;
      S_UNL_RD: lvl_ra = prio_rd_q;
      default:  lvl_ra = find.level;
    endcase
  end

  // link and unlink writes
  always_comb begin
    next_we  = 1'b0;
    prev_we  = 1'b0;
    head_we  = 1'b0;
    tail_we  = 1'b0;
    prio_we  = 1'b0;
    next_wa  = t_q;
    prev_wa  = t_q;
    next_wd  = t_q;
    prev_wd  = t_q;
    head_wd  = t_q;
    tail_wd  = t_q;
    bitmap_d = bitmap_q;
    queued_d = queued_q;
    case (state_q)
      S_LINK: begin
        prio_we          = 1'b1;
        queued_d[t_q]    = 1'b1;
        bitmap_d         = bitmap_q | p_mask;
        if ((bitmap_q & p_mask) == '0) begin
          head_we = 1'b1;
          tail_we = 1'b1;
        end else if (at_head_q) begin
          prev_we = 1'b1;
          prev_wa = head_rd_q;
          next_we = 1'b1;
          next_wd = head_rd_q;
          head_we = 1'b1;
        end else begin
          next_we = 1'b1;
          next_wa = tail_rd_q;
          prev_we = 1'b1;
          prev_wd = tail_rd_q;
          tail_we = 1'b1;
        end
      end
      S_UNL_WR: begin
        queued_d[t_q] = 1'b0;
        if (first && last) begin
          bitmap_d = bitmap_q & ~p_mask;
        end else begin
          if (first) begin
            head_we = 1'b1;
            head_wd = next_rd_q;
          end else begin
            next_we = 1'b1;
            next_wa = prev_rd_q;
            next_wd = next_rd_q;
          end
          if (last) begin
            tail_we = 1'b1;
            tail_wd = prev_rd_q;
          end else begin
            prev_we = 1'b1;
            prev_wa = next_rd_q;
            prev_wd = prev_rd_q;
          end
        end
      end
      default: begin
        bitmap_d = bitmap_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (prio_we) begin
      prio_mem[t_q] <= p_q;
    end
    next_rd_q <= next_mem[task_ra];
    prev_rd_q <= prev_mem[task_ra];
    prio_rd_q <= prio_mem[task_ra];
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[p_q] <= head_wd;
    end
    if (tail_we) begin
      tail_mem[p_q] <= tail_wd;
    end
    head_rd_q <= head_mem[lvl_ra];
    tail_rd_q <= tail_mem[lvl_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idle_task_q <= '0;
      bitmap_q    <= '0;
      queued_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bitmap_q <= bitmap_d;
      queued_q <= queued_d;
      if (cfg_we_i) begin
        idle_task_q <= cfg_wdata_i;
      end
      // in the report state a taken result is replaced by the new one
      if (m_axis_tvalid && m_axis_tready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_hs) begin
            t_q       <= idx_in;
            p_q       <= prio_sat;
            at_head_q <= (func_in == FUNC_ADD_HEAD);
            outcome_q <= outcome_d;
            if (go_link) begin
              state_q <= S_LINK;
            end else if (go_unlink) begin
              state_q <= S_UNL_RD;
            end else begin
              state_q <= S_RPT;
            end
          end
        end
        S_LINK: begin
          state_q <= S_RPT;
        end
        S_UNL_RD: begin
          p_q     <= prio_rd_q;
          state_q <= S_UNL_WR;
        end
        S_UNL_WR: begin
          state_q <= S_RPT;
        end
        S_RPT: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q   <= 1'b1;
            out_task_q    <= find.found ? head_rd_q : idle_task_q;
            out_idle_q    <= !find.found;
            out_levels_q  <= bitmap_q;
            out_outcome_q <= outcome_q;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // every non-empty level holds at least one queued task
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(bitmap_q) <= $countones(queued_q))
    else $error("more ready levels than queued tasks");

  // a link marks its task queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK) |=> queued_q[$past(t_q)])
    else $error("linked task not marked queued");

  // an ignored or blocked request leaves the queue untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_hs && (outcome_d != OUT_DONE)) |=> ($stable(bitmap_q) && $stable(queued_q)))
    else $error("ignored request changed the queue");

  // a result is only loaded from the report state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result presented outside the report state");

endmodule

`default_nettype wire
